// ----- src/assert_macros.svh -----
// assertion macros for the rtl files, included by slbc_engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ----- src/slbc_pkg.sv -----
// types and constants of the status led blink code generator
package slbc_pkg;

  localparam int unsigned TimeBits   = 32;
  localparam int unsigned DelayBits  = 16;
  localparam int unsigned CountBits  = 4;
  localparam int unsigned CfgIdxBits = 3;

  typedef logic [TimeBits-1:0]   time_t;
  typedef logic [DelayBits-1:0]  delay_t;
  typedef logic [CountBits-1:0]  count_t;
  typedef logic [CfgIdxBits-1:0] cfg_addr_t;

  localparam time_t  FaultPeriodMs = TimeBits'(100);
  localparam count_t CountMax      = '1;

  localparam delay_t ShortDelayRst      = DelayBits'(200);
  localparam delay_t LongDelayRst       = DelayBits'(1000);
  localparam count_t ReadyBlinksRst     = CountBits'(5);
  localparam count_t ConfiguredBlinksRst = CountBits'(1);
  localparam count_t ArmedBlinksRst     = CountBits'(2);
  localparam count_t FlightBlinksRst    = CountBits'(3);

  typedef enum logic [2:0] {
    ModeInit       = 3'd0,
    ModeConfigured = 3'd1,
    ModeArmed      = 3'd2,
    ModeTakeoff    = 3'd3,
    ModeFlying     = 3'd4,
    ModeFault      = 3'd5
  } mode_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgShortDelay       = 3'd0,
    CfgLongDelay        = 3'd1,
    CfgReadyBlinks      = 3'd2,
    CfgConfiguredBlinks = 3'd3,
    CfgArmedBlinks      = 3'd4,
    CfgFlightBlinks     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    delay_t short_delay_ms;
    delay_t long_delay_ms;
    count_t ready_blinks;
    count_t configured_blinks;
    count_t armed_blinks;
    count_t flight_blinks;
  } cfg_t;

  typedef struct packed {
    time_t current_time_ms;
    mode_e system_mode;
    logic  commands_ready;
  } poll_t;

  typedef struct packed {
    logic led_on;
    logic led_changed;
  } led_t;

endpackage

// ----- src/slbc_if.sv -----
// request channels: poll in, led level out
interface slbc_poll_if;
  logic                  valid;
  logic                  ready;
  slbc_pkg::time_t       current_time_ms;
  logic [2:0]            system_mode;
  logic                  commands_ready;

  modport source (output valid, current_time_ms, system_mode, commands_ready, input ready);
  modport sink (input valid, current_time_ms, system_mode, commands_ready, output ready);
endinterface

interface slbc_led_if;
  logic valid;
  logic ready;
  logic led_on;
  logic led_changed;

  modport source (output valid, led_on, led_changed, input ready);
  modport sink (input valid, led_on, led_changed, output ready);
endinterface

// ----- src/slbc_cfg_regs.sv -----
// configuration register file
module slbc_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  slbc_pkg::cfg_addr_t cfg_idx_i,
  input  slbc_pkg::delay_t    cfg_wdata_i,
  output slbc_pkg::cfg_t      cfg_o
);

  slbc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (slbc_pkg::cfg_idx_e'(cfg_idx_i))
        slbc_pkg::CfgShortDelay:       cfg_d.short_delay_ms = cfg_wdata_i;
        slbc_pkg::CfgLongDelay:        cfg_d.long_delay_ms = cfg_wdata_i;
        slbc_pkg::CfgReadyBlinks:
          cfg_d.ready_blinks = cfg_wdata_i[slbc_pkg::CountBits-1:0];
        slbc_pkg::CfgConfiguredBlinks:
          cfg_d.configured_blinks = cfg_wdata_i[slbc_pkg::CountBits-1:0];
        slbc_pkg::CfgArmedBlinks:
          cfg_d.armed_blinks = cfg_wdata_i[slbc_pkg::CountBits-1:0];
        slbc_pkg::CfgFlightBlinks:
          cfg_d.flight_blinks = cfg_wdata_i[slbc_pkg::CountBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_delay_ms    <= slbc_pkg::ShortDelayRst;
      cfg_q.long_delay_ms     <= slbc_pkg::LongDelayRst;
      cfg_q.ready_blinks      <= slbc_pkg::ReadyBlinksRst;
      cfg_q.configured_blinks <= slbc_pkg::ConfiguredBlinksRst;
      cfg_q.armed_blinks      <= slbc_pkg::ArmedBlinksRst;
      cfg_q.flight_blinks     <= slbc_pkg::FlightBlinksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/slbc_engine.sv -----
// pattern state and per-poll led update
`include "assert_macros.svh"

module slbc_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  slbc_pkg::poll_t  poll_i,
  input  slbc_pkg::cfg_t   cfg_i,
  output slbc_pkg::led_t   led_o
);

  logic                  shown_valid_q;
  slbc_pkg::mode_e       shown_mode_q;
  logic                  shown_ready_q;
  slbc_pkg::time_t       mark_q, mark_d;
  slbc_pkg::count_t      idx_q, idx_d;
  logic                  led_q, led_d;

  logic                  restart;
  slbc_pkg::time_t       now;
  slbc_pkg::time_t       mark_base;
  slbc_pkg::count_t      idx_base;
  logic                  led_base;
  slbc_pkg::time_t       elapsed;
  slbc_pkg::time_t       short_ext;
  slbc_pkg::time_t       long_ext;
  logic                  code_run;
  slbc_pkg::count_t      count_sel;
  logic                  group_done;

  assign now       = poll_i.current_time_ms;
  assign short_ext = slbc_pkg::TimeBits'(cfg_i.short_delay_ms);
  assign long_ext  = slbc_pkg::TimeBits'(cfg_i.long_delay_ms);

  assign restart = !shown_valid_q || (poll_i.system_mode != shown_mode_q)
                   || (poll_i.commands_ready != shown_ready_q);

  assign mark_base = restart ? now : mark_q;
  assign idx_base  = restart ? '0 : idx_q;
  assign led_base  = restart ? (poll_i.system_mode == slbc_pkg::ModeInit) : led_q;
  assign elapsed   = now - mark_base;

  always_comb begin
    mark_d    = mark_base;
    idx_d     = idx_base;
    led_d     = led_base;
    code_run  = 1'b0;
    count_sel = cfg_i.flight_blinks;
    case (poll_i.system_mode)
      slbc_pkg::ModeInit: begin
        if (poll_i.commands_ready) begin
          code_run  = 1'b1;
          count_sel = cfg_i.ready_blinks;
        end else if (elapsed >= long_ext) begin
          led_d  = !led_base;
          mark_d = now;
        end
      end
      slbc_pkg::ModeConfigured: begin
        code_run  = 1'b1;
        count_sel = cfg_i.configured_blinks;
      end
      slbc_pkg::ModeArmed: begin
        code_run  = 1'b1;
        count_sel = cfg_i.armed_blinks;
      end
      slbc_pkg::ModeTakeoff, slbc_pkg::ModeFlying: begin
        code_run  = 1'b1;
        count_sel = cfg_i.flight_blinks;
      end
      slbc_pkg::ModeFault: begin
        if (elapsed >= slbc_pkg::FaultPeriodMs) begin
          led_d  = !led_base;
          mark_d = now;
        end
      end
      default: ;
    endcase

    group_done = (idx_base >= count_sel);

    if (code_run) begin
      if (led_base) begin
        if (elapsed >= short_ext) begin
          led_d  = 1'b0;
          mark_d = now;
          if (idx_base != slbc_pkg::CountMax) begin
            idx_d = idx_base + 1'b1;
          end
        end
      end else if (elapsed >= (group_done ? long_ext : short_ext)) begin
        if (group_done) begin
          idx_d = '0;
        end
        led_d  = 1'b1;
        mark_d = now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_valid_q <= 1'b0;
      shown_mode_q  <= slbc_pkg::ModeInit;
      shown_ready_q <= 1'b0;
      mark_q        <= '0;
      idx_q         <= '0;
      led_q         <= 1'b0;
    end else if (step_i) begin
      shown_valid_q <= 1'b1;
      shown_mode_q  <= poll_i.system_mode;
      shown_ready_q <= poll_i.commands_ready;
      mark_q        <= mark_d;
      idx_q         <= idx_d;
      led_q         <= led_d;
    end
  end

  assign led_o.led_on      = led_d;
  assign led_o.led_changed = led_d != led_q;

  `ASSERT_PROP(a_hold_when_idle, clk_i, rst_ni,
               !step_i |=> $stable(led_q) && $stable(mark_q) && $stable(idx_q))
  `ASSERT_PROP(a_change_flag, clk_i, rst_ni,
               step_i |=> (led_q != $past(led_q)) == $past(led_o.led_changed))
  `ASSERT_NEVER(a_fault_early_toggle, clk_i, rst_ni,
                step_i && !restart && (poll_i.system_mode == slbc_pkg::ModeFault)
                && (elapsed < slbc_pkg::FaultPeriodMs) && led_o.led_changed)

endmodule

// ----- src/status_led_blink_code_generator_top.sv -----
// status led blink code generator, top level
//
//   channel  dir  payload                                          handshake
//   poll_i   in   current_time_ms, system_mode, commands_ready     valid/ready
//   led_o    out  led_on, led_changed                              valid/ready
//   cfg      in   cfg_idx_i, cfg_wdata_i                           cfg_we_i
//
// one poll per cycle while led_o is not stalled; a result is offered on led_o once its request
// has passed the input register and then the result register, the update logic sits between them
// reset clears the pattern state and loads the default configuration
// a stalled result register holds the input register, which then stalls the poll side
module status_led_blink_code_generator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  slbc_poll_if.sink           poll_i,
  slbc_led_if.source          led_o,
  input  logic                cfg_we_i,
  input  slbc_pkg::cfg_addr_t cfg_idx_i,
  input  slbc_pkg::delay_t    cfg_wdata_i
);

  slbc_pkg::cfg_t  cfg;
  slbc_pkg::poll_t s1_q;
  logic            s1_valid_q;
  logic            s1_fire;
  slbc_pkg::led_t  res;
  slbc_pkg::led_t  out_q;
  logic            out_valid_q;

  assign s1_fire      = s1_valid_q && (!out_valid_q || led_o.ready);
  assign poll_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (poll_i.ready) begin
      s1_valid_q <= poll_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_i.ready && poll_i.valid) begin
      s1_q.current_time_ms <= poll_i.current_time_ms;
      s1_q.system_mode     <= slbc_pkg::mode_e'(poll_i.system_mode);
      s1_q.commands_ready  <= poll_i.commands_ready;
    end
  end

  slbc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  slbc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_fire),
    .poll_i (s1_q),
    .cfg_i  (cfg),
    .led_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (led_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= res;
    end
  end

  assign led_o.valid       = out_valid_q;
  assign led_o.led_on      = out_q.led_on;
  assign led_o.led_changed = out_q.led_changed;

endmodule

// ----- bench/slbc_led_pattern_checker.sv -----
// checker for the status led blink code generator: predicts and compares led results
module slbc_led_pattern_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  slbc_poll_if                poll_i,
  slbc_led_if                 led_i,
  input  logic                cfg_we_i,
  input  slbc_pkg::cfg_addr_t cfg_idx_i,
  input  slbc_pkg::delay_t    cfg_wdata_i,
  output int unsigned         pending_o,
  output int unsigned         fail_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  slbc_pkg::cfg_t   shadow_cfg;
  logic             shown_valid;
  logic [2:0]       shown_mode;
  logic             shown_ready;
  slbc_pkg::time_t  mark_ms;
  slbc_pkg::count_t blink_idx;
  logic             led_lvl;
  slbc_pkg::led_t   pending_leds[$];
  int unsigned      fails = 0;

  function automatic void run_blink_code(slbc_pkg::time_t now, slbc_pkg::count_t count);
    slbc_pkg::time_t  elapsed;
    slbc_pkg::delay_t gap;
    elapsed = now - mark_ms;
    if (led_lvl) begin
      if (elapsed >= slbc_pkg::time_t'(shadow_cfg.short_delay_ms)) begin
        led_lvl = 1'b0;
        if (blink_idx != slbc_pkg::CountMax) blink_idx = blink_idx + 1'b1;
        mark_ms = now;
      end
    end else begin
      gap = (blink_idx >= count) ? shadow_cfg.long_delay_ms : shadow_cfg.short_delay_ms;
      if (elapsed >= slbc_pkg::time_t'(gap)) begin
        if (blink_idx >= count) blink_idx = '0;
        led_lvl = 1'b1;
        mark_ms = now;
      end
    end
  endfunction

  function automatic slbc_pkg::led_t predict_led(slbc_pkg::time_t now, logic [2:0] mode,
                                                 logic rdy);
    logic            lvl_before;
    slbc_pkg::time_t elapsed;
    slbc_pkg::led_t  res;
    lvl_before = led_lvl;
    // new mode or ready flag restarts the pattern
    if (!shown_valid || mode != shown_mode || rdy != shown_ready) begin
      shown_valid = 1'b1;
      shown_mode  = mode;
      shown_ready = rdy;
      mark_ms     = now;
      blink_idx   = '0;
      led_lvl     = (mode == slbc_pkg::ModeInit);
    end
    elapsed = now - mark_ms;
    case (mode)
      slbc_pkg::ModeInit: begin
        if (rdy) begin
          run_blink_code(now, shadow_cfg.ready_blinks);
        end else if (elapsed >= slbc_pkg::time_t'(shadow_cfg.long_delay_ms)) begin
          led_lvl = !led_lvl;
          mark_ms = now;
        end
      end
      slbc_pkg::ModeConfigured: run_blink_code(now, shadow_cfg.configured_blinks);
      slbc_pkg::ModeArmed: run_blink_code(now, shadow_cfg.armed_blinks);
      slbc_pkg::ModeTakeoff, slbc_pkg::ModeFlying:
        run_blink_code(now, shadow_cfg.flight_blinks);
      slbc_pkg::ModeFault: begin
        if (elapsed >= slbc_pkg::FaultPeriodMs) begin
          led_lvl = !led_lvl;
          mark_ms = now;
        end
      end
      default: ;
    endcase
    res.led_on      = led_lvl;
    res.led_changed = (led_lvl != lvl_before);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    slbc_pkg::led_t exp_led;
    if (!rst_ni) begin
      shadow_cfg.short_delay_ms    = slbc_pkg::ShortDelayRst;
      shadow_cfg.long_delay_ms     = slbc_pkg::LongDelayRst;
      shadow_cfg.ready_blinks      = slbc_pkg::ReadyBlinksRst;
      shadow_cfg.configured_blinks = slbc_pkg::ConfiguredBlinksRst;
      shadow_cfg.armed_blinks      = slbc_pkg::ArmedBlinksRst;
      shadow_cfg.flight_blinks     = slbc_pkg::FlightBlinksRst;
      shown_valid = 1'b0;
      shown_mode  = slbc_pkg::ModeInit;
      shown_ready = 1'b0;
      mark_ms     = '0;
      blink_idx   = '0;
      led_lvl     = 1'b0;
      pending_leds.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          slbc_pkg::CfgShortDelay: shadow_cfg.short_delay_ms = cfg_wdata_i;
          slbc_pkg::CfgLongDelay: shadow_cfg.long_delay_ms = cfg_wdata_i;
          slbc_pkg::CfgReadyBlinks:
            shadow_cfg.ready_blinks = cfg_wdata_i[slbc_pkg::CountBits-1:0];
          slbc_pkg::CfgConfiguredBlinks:
            shadow_cfg.configured_blinks = cfg_wdata_i[slbc_pkg::CountBits-1:0];
          slbc_pkg::CfgArmedBlinks:
            shadow_cfg.armed_blinks = cfg_wdata_i[slbc_pkg::CountBits-1:0];
          slbc_pkg::CfgFlightBlinks:
            shadow_cfg.flight_blinks = cfg_wdata_i[slbc_pkg::CountBits-1:0];
          default: ;
        endcase
      end
      if (led_i.valid && led_i.ready) begin
        if (pending_leds.size() == 0) begin
          fails++;
          $error("led result with no request pending: led_on %0b led_changed %0b",
                 led_i.led_on, led_i.led_changed);
        end else begin
          exp_led = pending_leds.pop_front();
          if (exp_led.led_on !== led_i.led_on) begin
            fails++;
            $error("led_on mismatch: expected %0b, actual %0b", exp_led.led_on, led_i.led_on);
          end
          if (exp_led.led_changed !== led_i.led_changed) begin
            fails++;
            $error("led_changed mismatch: expected %0b, actual %0b",
                   exp_led.led_changed, led_i.led_changed);
          end
        end
      end
      if (poll_i.valid && poll_i.ready) begin
        pending_leds.push_back(predict_led(poll_i.current_time_ms, poll_i.system_mode,
                                           poll_i.commands_ready));
      end
    end
    pending_o  <= pending_leds.size();
    fail_cnt_o <= fails;
  end

endmodule

// ----- bench/tb_status_led_blink_code_generator_top.sv -----
// testbench top: drives polls and configuration, stalls the led side, gives the verdict
module tb_status_led_blink_code_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]          ModeSpareLo = 3'd6;
  localparam logic [2:0]          ModeSpareHi = 3'd7;
  localparam slbc_pkg::cfg_addr_t CfgUnused   = 3'd6;
  localparam int unsigned         CycleLimit  = 400000;

  logic                clk_i;
  logic                rst_n;
  logic                cfg_we;
  slbc_pkg::cfg_addr_t cfg_idx;
  slbc_pkg::delay_t    cfg_wdata;
  int unsigned         pending;
  int unsigned         fail_cnt;
  int unsigned         cycles     = 0;
  int unsigned         burst_left = 0;
  int unsigned         gap_max    = 6;
  int unsigned         stall_pct  = 20;
  int unsigned         stall_left = 0;

  slbc_poll_if poll_ch ();
  slbc_led_if  led_ch ();

  status_led_blink_code_generator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .poll_i     (poll_ch),
    .led_o      (led_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  slbc_led_pattern_checker led_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .poll_i     (poll_ch),
    .led_i      (led_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .pending_o  (pending),
    .fail_cnt_o (fail_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      led_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      led_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 12);
    end
  end

  task automatic send_poll(slbc_pkg::time_t now, logic [2:0] mode, logic rdy);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        poll_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    poll_ch.valid           <= 1'b1;
    poll_ch.current_time_ms <= now;
    poll_ch.system_mode     <= mode;
    poll_ch.commands_ready  <= rdy;
    do @(posedge clk_i); while (!poll_ch.ready);
    burst_left--;
  endtask

  task automatic wait_idle();
    poll_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_cfg(slbc_pkg::cfg_t c);
    // unknown index first, must be ignored
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgUnused | slbc_pkg::cfg_addr_t'($urandom_range(0, 1));
    cfg_wdata <= slbc_pkg::delay_t'($urandom);
    @(posedge clk_i);
    cfg_idx   <= slbc_pkg::CfgShortDelay;
    cfg_wdata <= c.short_delay_ms;
    @(posedge clk_i);
    cfg_idx   <= slbc_pkg::CfgLongDelay;
    cfg_wdata <= c.long_delay_ms;
    @(posedge clk_i);
    cfg_idx   <= slbc_pkg::CfgReadyBlinks;
    cfg_wdata <= {12'($urandom), c.ready_blinks};
    @(posedge clk_i);
    cfg_idx   <= slbc_pkg::CfgConfiguredBlinks;
    cfg_wdata <= {12'($urandom), c.configured_blinks};
    @(posedge clk_i);
    cfg_idx   <= slbc_pkg::CfgArmedBlinks;
    cfg_wdata <= {12'($urandom), c.armed_blinks};
    @(posedge clk_i);
    cfg_idx   <= slbc_pkg::CfgFlightBlinks;
    cfg_wdata <= {12'($urandom), c.flight_blinks};
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_polls(int unsigned n_polls, int unsigned step_max);
    slbc_pkg::time_t now;
    logic [2:0]      mode;
    logic            rdy;
    int unsigned     hold;
    int unsigned     pick;
    now  = slbc_pkg::time_t'($urandom);
    hold = 0;
    mode = slbc_pkg::ModeInit;
    rdy  = 1'b0;
    repeat (n_polls) begin
      if (hold == 0) begin
        if ($urandom_range(0, 15) == 0) mode = 3'($urandom_range(ModeSpareLo, ModeSpareHi));
        else mode = 3'($urandom_range(slbc_pkg::ModeInit, slbc_pkg::ModeFault));
        rdy  = 1'($urandom);
        hold = $urandom_range(1, 120);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) now = now;
      else if (pick < 11) now = now + slbc_pkg::time_t'($urandom);
      else now = now + slbc_pkg::time_t'($urandom_range(1, step_max));
      // stray polls with another mode or ready flag break the running pattern
      if ($urandom_range(0, 39) == 0) send_poll(now, 3'($urandom), 1'($urandom));
      else send_poll(now, mode, rdy);
      hold--;
    end
  endtask

  initial begin
    slbc_pkg::cfg_t rand_cfg;
    poll_ch.valid           <= 1'b0;
    poll_ch.current_time_ms <= '0;
    poll_ch.system_mode     <= slbc_pkg::ModeInit;
    poll_ch.commands_ready  <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_idx                 <= slbc_pkg::CfgShortDelay;
    cfg_wdata               <= '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed walk through all modes with the default configuration
    send_poll(32'd0, slbc_pkg::ModeInit, 1'b0);
    send_poll(32'd999, slbc_pkg::ModeInit, 1'b0);
    send_poll(32'd1000, slbc_pkg::ModeInit, 1'b0);
    send_poll(32'd1000, slbc_pkg::ModeInit, 1'b1);
    send_poll(32'd1200, slbc_pkg::ModeInit, 1'b1);
    send_poll(32'd1400, slbc_pkg::ModeInit, 1'b1);
    send_poll(32'd1500, slbc_pkg::ModeConfigured, 1'b0);
    send_poll(32'd1700, slbc_pkg::ModeConfigured, 1'b0);
    send_poll(32'd1900, slbc_pkg::ModeConfigured, 1'b0);
    send_poll(32'd2900, slbc_pkg::ModeConfigured, 1'b0);
    send_poll(32'd3000, slbc_pkg::ModeArmed, 1'b1);
    send_poll(32'd3200, slbc_pkg::ModeArmed, 1'b1);
    send_poll(32'd4000, slbc_pkg::ModeTakeoff, 1'b0);
    send_poll(32'd4200, slbc_pkg::ModeFlying, 1'b0);
    send_poll(32'd4400, slbc_pkg::ModeFault, 1'b0);
    send_poll(32'd4500, slbc_pkg::ModeFault, 1'b0);
    send_poll(32'd4600, slbc_pkg::ModeFault, 1'b1);
    send_poll(32'd4700, ModeSpareLo, 1'b0);
    send_poll(32'd9000, ModeSpareHi, 1'b1);
    send_poll(32'hFFFF_FFA0, slbc_pkg::ModeFault, 1'b0);
    send_poll(32'h0000_0004, slbc_pkg::ModeFault, 1'b0);
    send_poll(32'hFFFF_FFFF, slbc_pkg::ModeInit, 1'b1);
    send_poll(32'h0000_00C7, slbc_pkg::ModeInit, 1'b1);
    send_poll(32'h8000_0000, slbc_pkg::ModeInit, 1'b0);
    run_polls(150, 150);

    // zero delays and zero blink counts, no idling
    wait_idle();
    gap_max   = 0;
    stall_pct = 0;
    load_cfg('{short_delay_ms: '0, long_delay_ms: '0, ready_blinks: '0,
               configured_blinks: '0, armed_blinks: '0, flight_blinks: '0});
    run_polls(150, 3);

    // largest delays and blink counts, heavy stalls
    wait_idle();
    gap_max   = 3;
    stall_pct = 50;
    load_cfg('{short_delay_ms: '1, long_delay_ms: '1, ready_blinks: '1,
               configured_blinks: '1, armed_blinks: '1, flight_blinks: '1});
    run_polls(150, 40000);

    repeat (6) begin
      wait_idle();
      gap_max   = $urandom_range(0, 8);
      stall_pct = $urandom_range(0, 60);
      rand_cfg.short_delay_ms    = slbc_pkg::delay_t'($urandom_range(1, 40));
      rand_cfg.long_delay_ms     = slbc_pkg::delay_t'($urandom_range(1, 120));
      rand_cfg.ready_blinks      = slbc_pkg::count_t'($urandom_range(0, 15));
      rand_cfg.configured_blinks = slbc_pkg::count_t'($urandom_range(0, 15));
      rand_cfg.armed_blinks      = slbc_pkg::count_t'($urandom_range(0, 15));
      rand_cfg.flight_blinks     = slbc_pkg::count_t'($urandom_range(0, 15));
      load_cfg(rand_cfg);
      run_polls(125, rand_cfg.short_delay_ms / 2 + 2);
    end

    poll_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/slbc_pkg.sv
src/slbc_if.sv
src/slbc_cfg_regs.sv
src/slbc_engine.sv
src/status_led_blink_code_generator_top.sv
bench/slbc_led_pattern_checker.sv
bench/tb_status_led_blink_code_generator_top.sv
